// File: rtl/md5_pkg.sv
package md5_pkg;

  // Four 32-bit words: chaining value, working registers, digest
  typedef logic [3:0][31:0] md5_words_t;

  // One message request as it enters the core
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } md5_req_t;

  localparam logic [31:0] PAD_BYTE_WORD = 32'h0000_0080;
  localparam logic [2:0]  FULL_BYTES    = 3'd4;

  // Initial chaining value, index 0 is A
  localparam md5_words_t INIT_CHAIN = {32'h10325476, 32'h98badcfe,
                                       32'hefcdab89, 32'h67452301};

  // Additive constant of each round
  function automatic logic [31:0] round_const(input logic [5:0] rnd);
    logic [31:0] k;
    unique case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount, indexed by {phase, round[1:0]}
  function automatic logic [4:0] round_shift(input logic [3:0] sel);
    logic [4:0] s;
    unique case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'((r4 << 2) + r4 + 4'd1);
      2'd2:    g = 4'((r4 << 1) + r4 + 4'd5);
      default: g = 4'((r4 << 3) - r4);
    endcase
    return g;
  endfunction

endpackage

// File: rtl/md5_round.sv
// One MD5 round step on the working registers
module md5_round
  import md5_pkg::*;
(
  input  logic [5:0]  rnd,
  input  md5_words_t  work,
  input  logic [31:0] msg,
  output md5_words_t  work_next
);

  logic [31:0] a, b, c, d;
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  sh;
  logic [63:0] rot_wide;

  assign a = work[0];
  assign b = work[1];
  assign c = work[2];
  assign d = work[3];

  // Round function by phase
  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign sum      = a + f + round_const(rnd) + msg;
  assign sh       = round_shift({rnd[5:4], rnd[1:0]});
  assign rot_wide = {sum, sum} << sh;

  // a <- d, b <- b + rotl(...), c <- b, d <- c
  assign work_next[0] = d;
  assign work_next[1] = b + rot_wide[63:32];
  assign work_next[2] = b;
  assign work_next[3] = c;

endmodule

// File: rtl/md5_core.sv
// Block buffer, padding sequencer and round sequencer
module md5_core
  import md5_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  output logic       req_ready,
  input  md5_req_t   req,
  output logic       dig_valid,
  input  logic       dig_ready,
  output md5_words_t digest
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_PRIME, ST_ROUND, ST_FOLD, ST_DIGEST
  } state_t;

  state_t       state_r;
  logic [3:0]   fill_r;
  logic [60:0]  len_r;
  logic [5:0]   rnd_r;
  logic         pad_act_r;
  logic         pad80_r;
  logic         lo_done_r;
  md5_words_t   chain_r;
  md5_words_t   work_r;
  md5_words_t   work_nxt;
  logic [31:0]  rdata_r;

  logic [31:0]  mem [16];
  logic         mem_we;
  logic [31:0]  mem_wdata;
  logic [3:0]   mem_raddr;

  logic [2:0]   nbytes;
  logic [31:0]  in_word;
  logic [60:0]  len_nxt;
  logic [31:0]  pad_word;
  logic         accept;

  // Effective byte count and pad byte merge for an incoming word
  always_comb begin
    nbytes = (!req.last || req.nbytes > FULL_BYTES) ? FULL_BYTES : req.nbytes;
    unique case (nbytes)
      3'd0:    in_word = PAD_BYTE_WORD;
      3'd1:    in_word = {16'h0, 8'h80, req.word[7:0]};
      3'd2:    in_word = {8'h0, 8'h80, req.word[15:0]};
      3'd3:    in_word = {8'h80, req.word[23:0]};
      default: in_word = req.word;
    endcase
  end

  assign len_nxt = len_r + 61'(nbytes);

  // Padding word for the current slot; the length goes in slots 14 and 15
  always_comb begin
    if (pad80_r) begin
      pad_word = PAD_BYTE_WORD;
    end else if (fill_r == 4'd14) begin
      pad_word = {len_r[28:0], 3'b000};
    end else if (fill_r == 4'd15 && lo_done_r) begin
      pad_word = len_r[60:29];
    end else begin
      pad_word = '0;
    end
  end

  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign mem_we    = accept || (state_r == ST_PAD);
  assign mem_wdata = (state_r == ST_PAD) ? pad_word : in_word;
  assign mem_raddr = (state_r == ST_ROUND) ? msg_index(rnd_r + 6'd1) : msg_index(6'd0);

  assign dig_valid = (state_r == ST_DIGEST);
  assign digest    = chain_r;

  // Block buffer: one write port at the fill slot, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  md5_round u_round (
    .rnd       (rnd_r),
    .work      (work_r),
    .msg       (rdata_r),
    .work_next (work_nxt)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      len_r     <= '0;
      rnd_r     <= '0;
      pad_act_r <= 1'b0;
      pad80_r   <= 1'b0;
      lo_done_r <= 1'b0;
      chain_r   <= INIT_CHAIN;
      work_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (req_valid) begin
            fill_r <= fill_r + 4'd1;
            len_r  <= len_nxt;
            if (req.last) begin
              pad_act_r <= 1'b1;
              pad80_r   <= (nbytes == FULL_BYTES);
              lo_done_r <= 1'b0;
            end
            if (fill_r == 4'd15) begin
              state_r <= ST_PRIME;
            end else if (req.last) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill_r  <= fill_r + 4'd1;
          pad80_r <= 1'b0;
          if (!pad80_r && fill_r == 4'd14) begin
            lo_done_r <= 1'b1;
          end
          if (fill_r == 4'd15) begin
            state_r <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          work_r  <= chain_r;
          rnd_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          work_r <= work_nxt;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int k = 0; k < 4; k++) begin
            chain_r[k] <= chain_r[k] + work_r[k];
          end
          if (pad_act_r && lo_done_r) begin
            state_r <= ST_DIGEST;
          end else if (pad_act_r) begin
            state_r <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_DIGEST: begin
          if (dig_ready) begin
            chain_r   <= INIT_CHAIN;
            work_r    <= '0;
            len_r     <= '0;
            pad_act_r <= 1'b0;
            pad80_r   <= 1'b0;
            lo_done_r <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The buffer is never written while a block is being compressed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRIME || state_r == ST_ROUND || state_r == ST_FOLD) |-> !mem_we)
    else $error("block buffer written during compression");

  // The last round hands over to the fold step
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_FOLD))
    else $error("round sequence did not end after 64 rounds");

  // A digest is offered only after a full final block
  assert property (@(posedge clk) disable iff (!rst_n)
    dig_valid |-> (fill_r == 4'd0 && lo_done_r && pad_act_r))
    else $error("digest offered with a partial block");

endmodule

// File: rtl/md5_digest_engine.sv
// MD5 digest engine. Message words enter little-endian (first byte in bits 7:0)
// with a byte count and a last mark; a short count is honored only on the last
// word, and a count of zero ends the message at the previous word. Each
// request is written into a 16-word block buffer. Every sixteenth word starts
// a compression (a read-prime step, 64 rounds at one round per cycle through a
// single round unit fed by the buffer's read port, and a fold step), during
// which no request is taken. After the last word the engine writes the
// padding and the 64-bit bit length one word per cycle and compresses one or
// two more blocks, then hands the four digest words A, B, C, D to an output
// buffer and is ready for the next message while they drain.
module md5_digest_engine
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_msg_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_digest_end
);

  md5_req_t   req;
  logic       dig_valid;
  logic       dig_ready;
  md5_words_t digest;

  md5_words_t buf_r;
  logic [1:0] idx_r;
  logic       busy_r;

  assign req = '{word: in_msg_word, nbytes: in_byte_count, last: in_last_word};

  md5_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .digest    (digest)
  );

  // Output buffer: takes a whole digest, then sends it one word per request
  assign dig_ready       = !busy_r;
  assign out_valid       = busy_r;
  assign out_digest_word = buf_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_digest_end  = (idx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (!busy_r) begin
      if (dig_valid) begin
        buf_r  <= digest;
        idx_r  <= '0;
        busy_r <= 1'b1;
      end
    end else if (out_ready) begin
      idx_r <= idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The buffer empties only when the final digest word has been taken
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(out_digest_end && out_ready))
    else $error("digest buffer emptied early");

  // A new digest is loaded only into an empty buffer, starting at word A
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> (idx_r == 2'd0))
    else $error("digest load did not start at word A");

  // The buffer keeps its place while the consumer stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ready) |=> (busy_r && $stable(idx_r)))
    else $error("digest word index moved without a request");

endmodule
